### sv/amle_pkg.sv
// Package for the AMLE pixel update block.
// Holds the controller state type and the command/status structs that join
// the controller and the datapath. No dependencies.
`default_nettype none

package amle_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_PREP,
        ST_PMUL,
        ST_DIV,
        ST_ROUND,
        ST_FIN
    } amle_state_t;

    // controller -> datapath
    typedef struct packed {
        logic in_en;     // input channel may take a transfer
        logic mul;       // form the score of the held neighbour
        logic cmp;       // update max/min trackers
        logic prep;      // weight sum, span and far weight
        logic pmul;      // far weight times span, divider init
        logic div_step;  // one restoring division step
        logic round;     // round quotient and add low value
        logic load_out;  // load the result register
    } amle_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_xfer;   // input transfer this cycle
        logic last;      // held item closes its run
        logic sum_zero;  // chosen weights sum to zero
        logic div_done;  // final division step this cycle
        logic out_free;  // result register can be loaded
    } amle_stat_t;

endpackage

`default_nettype wire

### sv/amle_in_if.sv
// Input channel of the AMLE pixel update block: one neighbour per transfer.
// Valid/ready handshake with source and sink modports. No dependencies.
`default_nettype none

interface amle_in_if #(
    parameter int VALUE_BITS  = 16,
    parameter int WEIGHT_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [VALUE_BITS-1:0]  center_value;
    logic [VALUE_BITS-1:0]  neighbour_value;
    logic [WEIGHT_BITS-1:0] neighbour_weight;
    logic                   last_neighbour;

    modport source (
        output valid, center_value, neighbour_value, neighbour_weight, last_neighbour,
        input  ready
    );
    modport sink (
        input  valid, center_value, neighbour_value, neighbour_weight, last_neighbour,
        output ready
    );
endinterface

`default_nettype wire

### sv/amle_out_if.sv
// Result channel of the AMLE pixel update block: one updated pixel per transfer.
// Valid/ready handshake with source and sink modports. No dependencies.
`default_nettype none

interface amle_out_if #(
    parameter int VALUE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] new_value;
    logic [VALUE_BITS-1:0] abs_change;
    logic                  zero_weight_sum;

    modport source (
        output valid, new_value, abs_change, zero_weight_sum,
        input  ready
    );
    modport sink (
        input  valid, new_value, abs_change, zero_weight_sum,
        output ready
    );
endinterface

`default_nettype wire

### sv/amle_pixel_update.sv
// Top level of the AMLE pixel update block.
// Depends on amle_pkg, amle_in_if, amle_out_if, amle_ctrl and amle_dp.
//
// One hole pixel's in-image neighbours arrive as a run, one per transfer on
// px_in; the center value is taken from the first transfer of a run. Each
// neighbour's score (value - center) * weight is tracked for its maximum and
// minimum (first of equal scores wins). After the transfer marked
// last_neighbour, upd_out gives the weighted mean of the two chosen
// neighbours, rounded to nearest with ties up, its absolute change from the
// center, and a flag when the chosen weights sum to zero (center kept).
// Items are handled one at a time: an item that is not last goes through
// accept, multiply and compare. A last item then goes through weight-sum
// prep, the far-weight product, the bit-serial division that forms the
// weighted mean, one step per product bit, rounding and the result load;
// a zero weight sum skips division and rounding. The result register lets
// the next run start while a result waits to be taken.
`default_nettype none

module amle_pixel_update #(
    parameter int VALUE_BITS  = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    amle_in_if.sink    px_in,
    amle_out_if.source upd_out
);
    import amle_pkg::*;

    amle_cmd_t  cmd;
    amle_stat_t stat;

    amle_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    amle_dp #(
        .VALUE_BITS  (VALUE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .px_in   (px_in),
        .upd_out (upd_out),
        .cmd     (cmd),
        .stat    (stat)
    );

endmodule

`default_nettype wire

### sv/amle_ctrl.sv
// Controller of the AMLE pixel update block: sequences score, compare,
// weighted-mean division and result load. Depends on amle_pkg.
`default_nettype none

module amle_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire amle_pkg::amle_stat_t stat,
    output amle_pkg::amle_cmd_t       cmd
);
    import amle_pkg::*;

    amle_state_t state_reg;
    amle_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_xfer)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = stat.last ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                // zero weight sum skips the division entirely
                state_next = stat.sum_zero ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:  cmd.in_en    = 1'b1;
            ST_MUL:   cmd.mul      = 1'b1;
            ST_CMP:   cmd.cmp      = 1'b1;
            ST_PREP:  cmd.prep     = 1'b1;
            ST_PMUL:  cmd.pmul     = 1'b1;
            ST_DIV:   cmd.div_step = 1'b1;
            ST_ROUND: cmd.round    = 1'b1;
            ST_FIN:   cmd.load_out = stat.out_free;
            default:  cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

### sv/amle_dp.sv
// Datapath of the AMLE pixel update block: score multiplier, max/min trackers,
// bit-serial divider for the weighted mean and the result register.
// Depends on amle_pkg, amle_in_if and amle_out_if.
`default_nettype none

module amle_dp #(
    parameter int VALUE_BITS  = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    amle_in_if.sink                  px_in,
    amle_out_if.source               upd_out,
    input  wire amle_pkg::amle_cmd_t cmd,
    output amle_pkg::amle_stat_t     stat
);
    import amle_pkg::*;

    localparam int MagBits = VALUE_BITS + WEIGHT_BITS;  // score magnitude
    localparam int SumBits = WEIGHT_BITS + 1;           // weight sum
    localparam int CntBits = $clog2(MagBits + 1);

    // input stage
    logic                   run_start_reg;
    logic                   first_reg;
    logic                   last_reg;
    logic [VALUE_BITS-1:0]  held_center_reg;
    logic [VALUE_BITS-1:0]  v_reg;
    logic [WEIGHT_BITS-1:0] wt_reg;
    logic                   neg_reg;
    logic [VALUE_BITS-1:0]  diff_reg;

    // trackers
    logic signed [MagBits:0] score_reg;
    logic signed [MagBits:0] max_score_reg;
    logic [VALUE_BITS-1:0]   max_value_reg;
    logic [WEIGHT_BITS-1:0]  max_weight_reg;
    logic signed [MagBits:0] min_score_reg;
    logic [VALUE_BITS-1:0]   min_value_reg;
    logic [WEIGHT_BITS-1:0]  min_weight_reg;

    // weighted mean
    logic [SumBits-1:0]     sum_reg;
    logic [VALUE_BITS-1:0]  lo_reg;
    logic [VALUE_BITS-1:0]  d_reg;
    logic [WEIGHT_BITS-1:0] wfar_reg;
    logic [MagBits-1:0]     p_reg;
    logic [SumBits-1:0]     rem_reg;
    logic [VALUE_BITS-1:0]  q_reg;
    logic [CntBits-1:0]     cnt_reg;
    logic [VALUE_BITS-1:0]  nv_reg;

    // result register
    logic                   out_valid_reg;
    logic [VALUE_BITS-1:0]  out_value_reg;
    logic [VALUE_BITS-1:0]  out_change_reg;
    logic                   out_zero_reg;

    logic                   in_xfer;
    logic [VALUE_BITS-1:0]  center_eff;
    logic [MagBits-1:0]     prod;
    logic [MagBits:0]       mag_ext;
    logic [SumBits:0]       trial;
    logic                   q_bit;
    logic [SumBits:0]       twice_rem;
    logic [VALUE_BITS-1:0]  q_rnd;
    logic                   sum_zero;
    logic                   out_free;

    assign px_in.ready = cmd.in_en;
    assign in_xfer     = px_in.valid && cmd.in_en;
    assign center_eff  = run_start_reg ? px_in.center_value : held_center_reg;

    assign prod    = MagBits'(diff_reg) * MagBits'(wt_reg);
    assign mag_ext = {1'b0, prod};

    // restoring division: shift in the next dividend bit, subtract when it fits
    assign trial = {rem_reg, p_reg[MagBits-1]};
    assign q_bit = (trial >= {1'b0, sum_reg});

    // round to nearest, ties up: 2r >= sum
    assign twice_rem = {rem_reg, 1'b0};
    assign q_rnd     = q_reg + VALUE_BITS'(twice_rem >= {1'b0, sum_reg});

    assign sum_zero = (sum_reg == '0);
    assign out_free = !out_valid_reg || upd_out.ready;

    assign stat.in_xfer  = in_xfer;
    assign stat.last     = last_reg;
    assign stat.sum_zero = sum_zero;
    assign stat.div_done = (cnt_reg == CntBits'(1));
    assign stat.out_free = out_free;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_start_reg <= 1'b1;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                run_start_reg <= px_in.last_neighbour;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (upd_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.pmul)
            begin
                cnt_reg <= CntBits'(MagBits);
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CntBits'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            held_center_reg <= center_eff;
            first_reg       <= run_start_reg;
            last_reg        <= px_in.last_neighbour;
            v_reg           <= px_in.neighbour_value;
            wt_reg          <= px_in.neighbour_weight;
            neg_reg         <= (px_in.neighbour_value < center_eff);
            diff_reg        <= (px_in.neighbour_value >= center_eff)
                               ? (px_in.neighbour_value - center_eff)
                               : (center_eff - px_in.neighbour_value);
        end

        if (cmd.mul)
        begin
            score_reg <= neg_reg ? -$signed(mag_ext) : $signed(mag_ext);
        end

        if (cmd.cmp)
        begin
            // strict compares: the first of equal scores stays
            if (first_reg || (score_reg > max_score_reg))
            begin
                max_score_reg  <= score_reg;
                max_value_reg  <= v_reg;
                max_weight_reg <= wt_reg;
            end
            if (first_reg || (score_reg < min_score_reg))
            begin
                min_score_reg  <= score_reg;
                min_value_reg  <= v_reg;
                min_weight_reg <= wt_reg;
            end
        end

        if (cmd.prep)
        begin
            sum_reg <= SumBits'(max_weight_reg) + SumBits'(min_weight_reg);
            if (max_value_reg >= min_value_reg)
            begin
                lo_reg   <= min_value_reg;
                d_reg    <= max_value_reg - min_value_reg;
                wfar_reg <= max_weight_reg;
            end
            else
            begin
                lo_reg   <= max_value_reg;
                d_reg    <= min_value_reg - max_value_reg;
                wfar_reg <= min_weight_reg;
            end
        end

        if (cmd.pmul)
        begin
            p_reg   <= MagBits'(wfar_reg) * MagBits'(d_reg);
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            p_reg   <= {p_reg[MagBits-2:0], 1'b0};
            rem_reg <= q_bit ? SumBits'(trial - {1'b0, sum_reg}) : trial[SumBits-1:0];
            // quotient never exceeds the span, so bits shifted out are zero
            q_reg   <= {q_reg[VALUE_BITS-2:0], q_bit};
        end

        if (cmd.round)
        begin
            nv_reg <= lo_reg + q_rnd;
        end

        if (cmd.load_out)
        begin
            if (sum_zero)
            begin
                out_value_reg  <= held_center_reg;
                out_change_reg <= '0;
                out_zero_reg   <= 1'b1;
            end
            else
            begin
                out_value_reg  <= nv_reg;
                out_change_reg <= (nv_reg >= held_center_reg)
                                  ? (nv_reg - held_center_reg)
                                  : (held_center_reg - nv_reg);
                out_zero_reg   <= 1'b0;
            end
        end
    end

    assign upd_out.valid           = out_valid_reg;
    assign upd_out.new_value       = out_value_reg;
    assign upd_out.abs_change      = out_change_reg;
    assign upd_out.zero_weight_sum = out_zero_reg;

endmodule

`default_nettype wire

### sim/amle_pixel_update_tb.sv
// Testbench for amle_pixel_update: neighbour runs in on px_in, updated pixels out on upd_out.
// Needs amle_pkg, amle_in_if, amle_out_if and the block itself. Self-checking against
// a built-in model of the max/min score tracking and the rounded weighted mean.

module amle_pixel_update_tb;

    localparam int VB           = 16;
    localparam int WB           = 16;
    localparam int TAIL_ITEMS   = 250;     // no idling once this few items remain
    localparam int RANDOM_ITEMS = 1900;
    localparam int HOLD_AFTER   = 600;     // accepted items before the long output stall
    localparam int HOLD_CYCLES  = 500;
    localparam int DRAIN_CYCLES = 60;      // longer than the processing of a last item
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [VB-1:0] center_value;
        logic [VB-1:0] neighbour_value;
        logic [WB-1:0] neighbour_weight;
        logic          last_neighbour;
    } neighbour_t;

    typedef struct packed {
        logic [VB-1:0] new_value;
        logic [VB-1:0] abs_change;
        logic          zero_weight_sum;
    } pixel_update_t;

    logic clk = 1'b0;
    logic rst_n;

    amle_in_if  #(.VALUE_BITS(VB), .WEIGHT_BITS(WB)) px_bus ();
    amle_out_if #(.VALUE_BITS(VB))                   upd_bus ();

    amle_pixel_update #(
        .VALUE_BITS  (VB),
        .WEIGHT_BITS (WB)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .px_in   (px_bus),
        .upd_out (upd_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    neighbour_t    pending_items[$];
    pixel_update_t expected_updates[$];
    int unsigned   fail_count     = 0;
    int unsigned   accepted_items = 0;
    int unsigned   cycle_count    = 0;

    // model state of the pixel being updated
    logic          at_run_start = 1'b1;
    logic [VB-1:0] held_center  = '0;
    longint        top_score    = 0;
    logic [VB-1:0] top_value    = '0;
    logic [WB-1:0] top_weight   = '0;
    longint        bot_score    = 0;
    logic [VB-1:0] bot_value    = '0;
    logic [WB-1:0] bot_weight   = '0;

    function automatic void absorb_neighbour(neighbour_t it);
        longint          score;
        longint unsigned wsum;
        longint unsigned low_v;
        longint unsigned span;
        longint unsigned far_w;
        longint unsigned prod;
        longint unsigned quo;
        longint unsigned rem;
        pixel_update_t   res;
        if (at_run_start)
            held_center = it.center_value;
        score = (longint'(it.neighbour_value) - longint'(held_center))
                * longint'(it.neighbour_weight);
        if (at_run_start)
        begin
            top_score = score; top_value = it.neighbour_value; top_weight = it.neighbour_weight;
            bot_score = score; bot_value = it.neighbour_value; bot_weight = it.neighbour_weight;
            at_run_start = 1'b0;
        end
        else
        begin
            // strict compares: the first of equal scores stays
            if (score > top_score)
            begin
                top_score = score; top_value = it.neighbour_value;
                top_weight = it.neighbour_weight;
            end
            if (score < bot_score)
            begin
                bot_score = score; bot_value = it.neighbour_value;
                bot_weight = it.neighbour_weight;
            end
        end
        if (!it.last_neighbour)
            return;
        at_run_start = 1'b1;
        wsum = longint'(top_weight) + longint'(bot_weight);
        if (wsum == 0)
        begin
            res.new_value       = held_center;
            res.abs_change      = '0;
            res.zero_weight_sum = 1'b1;
        end
        else
        begin
            if (top_value >= bot_value)
            begin
                low_v = bot_value;
                span  = top_value - bot_value;
                far_w = top_weight;
            end
            else
            begin
                low_v = top_value;
                span  = bot_value - top_value;
                far_w = bot_weight;
            end
            prod = far_w * span;
            quo  = prod / wsum;
            rem  = prod % wsum;
            if (rem >= wsum - rem)   // ties round up
                quo = quo + 1;
            res.new_value       = VB'(low_v + quo);
            res.abs_change      = (res.new_value >= held_center) ?
                                  res.new_value - held_center : held_center - res.new_value;
            res.zero_weight_sum = 1'b0;
        end
        expected_updates.push_back(res);
    endfunction

    task automatic add_item(input logic [VB-1:0] c, input logic [VB-1:0] v,
                            input logic [WB-1:0] w, input logic last);
        neighbour_t it;
        it.center_value     = c;
        it.neighbour_value  = v;
        it.neighbour_weight = w;
        it.last_neighbour   = last;
        pending_items.push_back(it);
    endtask

    function automatic logic [VB-1:0] pick_value(logic [VB-1:0] ctr);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return ctr;
            3:       return ctr + VB'($urandom_range(0, 15)) - VB'(8);
            default: return VB'($urandom);
        endcase
    endfunction

    function automatic logic [WB-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return WB'($urandom_range(1, 4));
            3:       return WB'(4096);
            default: return WB'($urandom);
        endcase
    endfunction

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 5;
            default: return 25;
        endcase
    endfunction

    task automatic queue_run(input int len);
        logic [VB-1:0] ctr;
        logic [VB-1:0] v;
        logic [WB-1:0] w;
        ctr = ($urandom_range(0, 7) == 0) ? {VB{$urandom_range(0, 1) == 1}} : VB'($urandom);
        v   = pick_value(ctr);
        w   = pick_weight();
        for (int i = 0; i < len; i++)
        begin
            // repeating the previous neighbour forces equal scores
            if (i == 0 || $urandom_range(0, 5) != 0)
            begin
                v = pick_value(ctr);
                w = pick_weight();
            end
            add_item((i == 0) ? ctr : VB'($urandom), v, w, i == len - 1);
        end
    endtask

    // input side
    int         tx_gap    = 0;
    int         tx_rate   = 0;
    int         tx_span   = 0;
    int         hold_left = 0;
    neighbour_t next_item;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (px_bus.valid && px_bus.ready)
            begin
                absorb_neighbour('{px_bus.center_value, px_bus.neighbour_value,
                                   px_bus.neighbour_weight, px_bus.last_neighbour});
                accepted_items++;
            end
            if (tx_span == 0)
            begin
                tx_span = $urandom_range(50, 400);
                tx_rate = pick_rate();
            end
            tx_span--;
            if (!px_bus.valid || px_bus.ready)
            begin
                if (tx_gap == 0 && hold_left == 0 && pending_items.size() > TAIL_ITEMS
                    && $urandom_range(0, 99) < tx_rate)
                    tx_gap = $urandom_range(1, 13);
                if (tx_gap != 0 || pending_items.size() == 0)
                begin
                    if (tx_gap != 0)
                        tx_gap--;
                    px_bus.valid <= 1'b0;
                end
                else
                begin
                    next_item = pending_items.pop_front();
                    px_bus.valid            <= 1'b1;
                    px_bus.center_value     <= next_item.center_value;
                    px_bus.neighbour_value  <= next_item.neighbour_value;
                    px_bus.neighbour_weight <= next_item.neighbour_weight;
                    px_bus.last_neighbour   <= next_item.last_neighbour;
                end
            end
        end
    end

    // result side
    int            rx_gap    = 0;
    int            rx_rate   = 0;
    int            rx_span   = 0;
    logic          hold_done = 1'b0;
    pixel_update_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (upd_bus.valid && upd_bus.ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    $error("unexpected result transfer: new_value %0d abs_change %0d",
                           upd_bus.new_value, upd_bus.abs_change);
                    fail_count++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (upd_bus.new_value !== want.new_value)
                    begin
                        $error("new_value: expected %0d, got %0d",
                               want.new_value, upd_bus.new_value);
                        fail_count++;
                    end
                    if (upd_bus.abs_change !== want.abs_change)
                    begin
                        $error("abs_change: expected %0d, got %0d",
                               want.abs_change, upd_bus.abs_change);
                        fail_count++;
                    end
                    if (upd_bus.zero_weight_sum !== want.zero_weight_sum)
                    begin
                        $error("zero_weight_sum: expected %0d, got %0d",
                               want.zero_weight_sum, upd_bus.zero_weight_sum);
                        fail_count++;
                    end
                end
            end
            // one long stall so the result register fills and px_in backs up
            if (!hold_done && accepted_items >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (rx_span == 0)
            begin
                rx_span = $urandom_range(50, 400);
                rx_rate = pick_rate();
            end
            rx_span--;
            if (hold_left != 0)
            begin
                hold_left--;
                upd_bus.ready <= 1'b0;
            end
            else
            begin
                if (rx_gap == 0 && pending_items.size() > TAIL_ITEMS
                    && $urandom_range(0, 99) < rx_rate)
                    rx_gap = $urandom_range(1, 13);
                if (rx_gap != 0)
                begin
                    rx_gap--;
                    upd_bus.ready <= 1'b0;
                end
                else
                    upd_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n                   = 1'b0;
        px_bus.valid            = 1'b0;
        px_bus.center_value     = '0;
        px_bus.neighbour_value  = '0;
        px_bus.neighbour_weight = '0;
        px_bus.last_neighbour   = 1'b0;
        upd_bus.ready           = 1'b0;

        // single-neighbour runs: zero weight, full-scale up and down
        add_item(16'd0,     16'd0,     16'd0,     1'b1);
        add_item(16'd0,     16'd65535, 16'd65535, 1'b1);
        add_item(16'd65535, 16'd0,     16'd65535, 1'b1);
        // rounding tie goes to the larger value
        add_item(16'd0,     16'd0,     16'd1,     1'b0);
        add_item(16'd999,   16'd1,     16'd1,     1'b1);
        // equal scores on both ends: first seen stays, later centers ignored
        add_item(16'd100,   16'd110,   16'd6,     1'b0);
        add_item(16'd0,     16'd112,   16'd5,     1'b0);
        add_item(16'd1234,  16'd90,    16'd3,     1'b0);
        add_item(16'd0,     16'd97,    16'd10,    1'b1);
        // max neighbour below min neighbour in value
        add_item(16'd100,   16'd60,    16'd1,     1'b0);
        add_item(16'd100,   16'd50,    16'd0,     1'b1);
        // all weights zero in a longer run: center kept
        add_item(16'd500,   16'd10,    16'd0,     1'b0);
        add_item(16'd7,     16'd65535, 16'd0,     1'b1);
        // zero score below the center counts as plain zero
        add_item(16'd200,   16'd100,   16'd0,     1'b0);
        add_item(16'd200,   16'd300,   16'd0,     1'b0);
        add_item(16'd200,   16'd150,   16'd2,     1'b1);
        // largest products of both signs
        add_item(16'd32768, 16'd65535, 16'd65535, 1'b0);
        add_item(16'd32768, 16'd0,     16'd65535, 1'b0);
        add_item(16'd32768, 16'd32768, 16'd40000, 1'b1);
        add_item(16'd65535, 16'd65535, 16'd65535, 1'b0);
        add_item(16'd0,     16'd0,     16'd65535, 1'b1);

        while (pending_items.size() < RANDOM_ITEMS)
            queue_run(($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || px_bus.valid || expected_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_updates.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
sv/amle_pkg.sv
sv/amle_in_if.sv
sv/amle_out_if.sv
sv/amle_ctrl.sv
sv/amle_dp.sv
sv/amle_pixel_update.sv
sim/amle_pixel_update_tb.sv
